### src/mhtq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mhtq_pkg;

  // Heap geometry. Slots are numbered 1..HEAP_DEPTH, memory addresses are slot - 1.
  localparam int HEAP_DEPTH = 64;
  localparam int SLOT_W     = $clog2(HEAP_DEPTH + 1);
  localparam int ADDR_W     = $clog2(HEAP_DEPTH);

  // Field widths.
  localparam int KIND_W    = 2;
  localparam int SEC_W     = 32;
  localparam int USEC_W    = 20;
  localparam int TIME_W    = SEC_W + USEC_W;
  localparam int DELAY_W   = 32;
  localparam int JOB_W     = 16;
  localparam int PENDING_W = 7;
  localparam int ENTRY_W   = TIME_W + JOB_W;

  // Stream word widths.
  localparam int IN_FIELDS_W  = 2 * SEC_W + 2 * USEC_W + DELAY_W + JOB_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = JOB_W + PENDING_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Millisecond split: delay / 1000 by a reciprocal that is exact for 32-bit operands.
  localparam int                MS_RECIP_W = 29;
  localparam logic [28:0]       MS_RECIP   = 29'd274877907;
  localparam int                MS_SHIFT   = 38;
  localparam int                MS_PROD_W  = DELAY_W + MS_RECIP_W;
  localparam int                MS_QUOT_W  = MS_PROD_W - MS_SHIFT;
  localparam int                MS_REM_W   = 10;
  localparam logic [9:0]        MS_PER_SEC = 10'd1000;
  localparam int                USUM_W     = USEC_W + 1;
  localparam logic [20:0]       USEC_PER_SEC = 21'd1000000;

  typedef enum logic [KIND_W-1:0] {
    KIND_INS_ABS  = 2'd0,
    KIND_INS_SEC  = 2'd1,
    KIND_INS_MSEC = 2'd2,
    KIND_POLL     = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [SEC_W-1:0]   now_sec;
    logic [USEC_W-1:0]  now_usec;
    logic [SEC_W-1:0]   deadline_sec;
    logic [USEC_W-1:0]  deadline_usec;
    logic [DELAY_W-1:0] delay;
    logic [JOB_W-1:0]   job_handle;
  } item_t;

  typedef struct packed {
    logic                 fired;
    logic [JOB_W-1:0]     job_out;
    logic [PENDING_W-1:0] pending;
    logic                 dropped;
  } result_t;

  typedef struct packed {
    logic [TIME_W-1:0] tstamp;
    logic [JOB_W-1:0]  job;
  } entry_t;

endpackage

`default_nettype wire

### src/min_heap_timer_queue_core.sv
// Timer queue on a binary min-heap in one 64-entry memory with one read and one write port.
// A dropped insert or an empty poll goes straight to the result; an early poll reads and compares the root;
// an insert computes its deadline, then climbs while it is strictly earlier than its parent;
// a fired poll moves the last word to the root and descends while a child is strictly earlier.
// One word at a time; the next is taken the cycle after the result moved into the output register.
// Async active-low reset empties the heap, idles the sequencer and clears output valid, not the memory.
`timescale 1ns / 1ps
`default_nettype none

module min_heap_timer_queue_core (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // now_sec, now_usec, deadline_sec, deadline_usec, delay, job_handle
  input  wire logic [mhtq_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // kind
  input  wire logic [mhtq_pkg::KIND_W-1:0]           s_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // job_out, pending, dropped
  output logic [mhtq_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,
  // fired
  output logic [0:0]                                 m_axis_tuser
);

  mhtq_pkg::item_t    item;
  mhtq_pkg::result_t  res;
  logic               idle;
  logic               res_valid;
  logic               res_ready;
  logic               out_valid_q;
  mhtq_pkg::result_t  out_q;

  assign item.kind          = mhtq_pkg::kind_e'(s_axis_tuser);
  assign item.now_sec       = s_axis_tdata[31:0];
  assign item.now_usec      = s_axis_tdata[51:32];
  assign item.deadline_sec  = s_axis_tdata[83:52];
  assign item.deadline_usec = s_axis_tdata[103:84];
  assign item.delay         = s_axis_tdata[135:104];
  assign item.job_handle    = s_axis_tdata[151:136];

  assign s_axis_tready = idle;

  mhtq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (s_axis_tvalid && idle),
    .item_i      (item),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register frees the sequencer while a word waits downstream.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = mhtq_pkg::OUT_TDATA_W'({out_q.dropped, out_q.pending, out_q.job_out});
  assign m_axis_tuser  = out_q.fired;

endmodule

`default_nettype wire

### src/mhtq_time_calc.sv
`timescale 1ns / 1ps
`default_nettype none

// Computes the deadline of an insert word over four registered steps:
// reciprocal multiply, remainder, microsecond sum, carry and saturation.
module mhtq_time_calc (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire mhtq_pkg::item_t            item_i,
  output logic                            done_o,
  output logic [mhtq_pkg::TIME_W-1:0]     time_o
);

  logic [3:0]                        vld_q;
  mhtq_pkg::item_t                   item_q;
  logic [mhtq_pkg::MS_PROD_W-1:0]    prod_q;
  logic [mhtq_pkg::MS_QUOT_W-1:0]    quot_q;
  logic [mhtq_pkg::MS_REM_W-1:0]     rem_q;
  logic [mhtq_pkg::USUM_W-1:0]       usum_q;
  logic [mhtq_pkg::TIME_W-1:0]       time_q;

  logic [mhtq_pkg::MS_QUOT_W-1:0]    quot_w;
  logic [mhtq_pkg::DELAY_W:0]        quot_ms;
  logic [mhtq_pkg::DELAY_W-1:0]      rem_full;
  logic                              carry;
  logic [mhtq_pkg::DELAY_W-1:0]      addend;
  logic [mhtq_pkg::SEC_W:0]          sec_sum;
  logic [mhtq_pkg::SEC_W-1:0]        sec_sat;
  logic [mhtq_pkg::USUM_W-1:0]       usum_fix;
  logic [mhtq_pkg::USEC_W-1:0]       usec_sel;
  logic [mhtq_pkg::TIME_W-1:0]       time_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start_i};
    end
  end

  assign quot_w   = prod_q[mhtq_pkg::MS_SHIFT +: mhtq_pkg::MS_QUOT_W];
  assign quot_ms  = (mhtq_pkg::DELAY_W + 1)'(quot_w) *
                    (mhtq_pkg::DELAY_W + 1)'(mhtq_pkg::MS_PER_SEC);
  assign rem_full = item_q.delay - quot_ms[mhtq_pkg::DELAY_W-1:0];

  always_comb begin
    carry    = (item_q.kind == mhtq_pkg::KIND_INS_MSEC) && (usum_q >= mhtq_pkg::USEC_PER_SEC);
    addend   = (item_q.kind == mhtq_pkg::KIND_INS_SEC) ? item_q.delay
                                                       : mhtq_pkg::DELAY_W'(quot_q);
    sec_sum  = (mhtq_pkg::SEC_W + 1)'(item_q.now_sec) + (mhtq_pkg::SEC_W + 1)'(addend) +
               (mhtq_pkg::SEC_W + 1)'(carry);
    sec_sat  = sec_sum[mhtq_pkg::SEC_W] ? '1 : sec_sum[mhtq_pkg::SEC_W-1:0];
    usum_fix = carry ? (usum_q - mhtq_pkg::USEC_PER_SEC) : usum_q;
    usec_sel = (item_q.kind == mhtq_pkg::KIND_INS_SEC) ? item_q.now_usec
                                                       : usum_fix[mhtq_pkg::USEC_W-1:0];
    if (item_q.kind == mhtq_pkg::KIND_INS_ABS) begin
      time_d = {item_q.deadline_sec, item_q.deadline_usec};
    end else begin
      time_d = {sec_sat, usec_sel};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      item_q <= item_i;
      prod_q <= mhtq_pkg::MS_PROD_W'(item_i.delay) * mhtq_pkg::MS_PROD_W'(mhtq_pkg::MS_RECIP);
    end
    if (vld_q[0]) begin
      quot_q <= quot_w;
      rem_q  <= rem_full[mhtq_pkg::MS_REM_W-1:0];
    end
    if (vld_q[1]) begin
      usum_q <= mhtq_pkg::USUM_W'(item_q.now_usec) +
                mhtq_pkg::USUM_W'(20'(rem_q) * 20'(mhtq_pkg::MS_PER_SEC));
    end
    if (vld_q[2]) begin
      time_q <= time_d;
    end
  end

  assign done_o = vld_q[3];
  assign time_o = time_q;

endmodule

`default_nettype wire

### src/mhtq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mhtq_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

### src/mhtq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Heap sequencer: one memory port each way and one shared deadline comparator.
module mhtq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire mhtq_pkg::item_t   item_i,
  output logic                   idle_o,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output mhtq_pkg::result_t      res_o
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_CALC     = 11'b000_0000_0010,
    S_UP_CHK   = 11'b000_0000_0100,
    S_UP_CMP   = 11'b000_0000_1000,
    S_POP_ROOT = 11'b000_0001_0000,
    S_POP_LAST = 11'b000_0010_0000,
    S_DN_CHK   = 11'b000_0100_0000,
    S_DN_LEFT  = 11'b000_1000_0000,
    S_DN_RIGHT = 11'b001_0000_0000,
    S_DN_CMP   = 11'b010_0000_0000,
    S_DONE     = 11'b100_0000_0000
  } state_e;

  function automatic logic [mhtq_pkg::ADDR_W-1:0] slot_addr(
    input logic [mhtq_pkg::SLOT_W-1:0] slot
  );
    logic [mhtq_pkg::SLOT_W-1:0] m;
    m = slot - 1'b1;
    return m[mhtq_pkg::ADDR_W-1:0];
  endfunction

  state_e                         state_q, state_d;
  logic [mhtq_pkg::SLOT_W-1:0]    total_q, total_d;
  logic [mhtq_pkg::SLOT_W-1:0]    pos_q, pos_d;
  logic [mhtq_pkg::SLOT_W-1:0]    cidx_q, cidx_d;
  logic [mhtq_pkg::TIME_W-1:0]    t_q, t_d;
  logic [mhtq_pkg::TIME_W-1:0]    now_q, now_d;
  logic [mhtq_pkg::JOB_W-1:0]     job_q, job_d;
  mhtq_pkg::entry_t               cand_q, cand_d;
  logic                           fired_q, fired_d;
  logic [mhtq_pkg::JOB_W-1:0]     jout_q, jout_d;
  logic                           drop_q, drop_d;

  logic                           calc_start;
  logic                           calc_done;
  logic [mhtq_pkg::TIME_W-1:0]    calc_time;

  logic                           rd_en;
  logic [mhtq_pkg::ADDR_W-1:0]    rd_addr;
  mhtq_pkg::entry_t               rd_data;
  logic                           wr_en;
  logic [mhtq_pkg::ADDR_W-1:0]    wr_addr;
  mhtq_pkg::entry_t               wr_data;

  logic [mhtq_pkg::TIME_W-1:0]    cmp_a, cmp_b;
  logic                           cmp_lt;
  logic [mhtq_pkg::SLOT_W:0]      child_w;
  logic [mhtq_pkg::SLOT_W:0]      total_ext;

  mhtq_time_calc u_calc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (calc_start),
    .item_i  (item_i),
    .done_o  (calc_done),
    .time_o  (calc_time)
  );

  mhtq_ram #(
    .DATA_W (mhtq_pkg::ENTRY_W),
    .ADDR_W (mhtq_pkg::ADDR_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // The single comparator; its operands follow the state.
  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    case (state_q)
      S_UP_CMP: begin
        cmp_a = t_q;
        cmp_b = rd_data.tstamp;
      end
      S_POP_ROOT: begin
        cmp_a = now_q;
        cmp_b = rd_data.tstamp;
      end
      S_DN_RIGHT: begin
        cmp_a = rd_data.tstamp;
        cmp_b = cand_q.tstamp;
      end
      S_DN_CMP: begin
        cmp_a = cand_q.tstamp;
        cmp_b = t_q;
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  assign cmp_lt    = cmp_a < cmp_b;
  assign child_w   = {pos_q, 1'b0};
  assign total_ext = (mhtq_pkg::SLOT_W + 1)'(total_q);

  always_comb begin
    state_d    = state_q;
    total_d    = total_q;
    pos_d      = pos_q;
    cidx_d     = cidx_q;
    t_d        = t_q;
    now_d      = now_q;
    job_d      = job_q;
    cand_d     = cand_q;
    fired_d    = fired_q;
    jout_d     = jout_q;
    drop_d     = drop_q;
    calc_start = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = slot_addr(pos_q);
    wr_data    = {t_q, job_q};

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          now_d   = {item_i.now_sec, item_i.now_usec};
          job_d   = item_i.job_handle;
          fired_d = 1'b0;
          jout_d  = '0;
          drop_d  = 1'b0;
          if (item_i.kind == mhtq_pkg::KIND_POLL) begin
            if (total_q == '0) begin
              state_d = S_DONE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = '0;
              state_d = S_POP_ROOT;
            end
          end else if (total_q == mhtq_pkg::SLOT_W'(mhtq_pkg::HEAP_DEPTH)) begin
            drop_d  = 1'b1;
            state_d = S_DONE;
          end else begin
            calc_start = 1'b1;
            state_d    = S_CALC;
          end
        end
      end
      S_CALC: begin
        if (calc_done) begin
          t_d     = calc_time;
          total_d = total_q + 1'b1;
          pos_d   = total_q + 1'b1;
          state_d = S_UP_CHK;
        end
      end
      S_UP_CHK: begin
        if (pos_q > mhtq_pkg::SLOT_W'(1)) begin
          rd_en   = 1'b1;
          rd_addr = slot_addr(pos_q >> 1);
          state_d = S_UP_CMP;
        end else begin
          wr_en   = 1'b1;
          state_d = S_DONE;
        end
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (cmp_lt) begin
          // Parent is strictly later: it moves down one level.
          wr_data = rd_data;
          pos_d   = pos_q >> 1;
          state_d = S_UP_CHK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_POP_ROOT: begin
        if (cmp_lt) begin
          state_d = S_DONE;
        end else begin
          fired_d = 1'b1;
          jout_d  = rd_data.job;
          rd_en   = 1'b1;
          rd_addr = slot_addr(total_q);
          total_d = total_q - 1'b1;
          state_d = S_POP_LAST;
        end
      end
      S_POP_LAST: begin
        t_d     = rd_data.tstamp;
        job_d   = rd_data.job;
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = rd_data;
        pos_d   = mhtq_pkg::SLOT_W'(1);
        if (total_q > mhtq_pkg::SLOT_W'(1)) begin
          state_d = S_DN_CHK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DN_CHK: begin
        if (child_w <= total_ext) begin
          rd_en   = 1'b1;
          rd_addr = slot_addr(child_w[mhtq_pkg::SLOT_W-1:0]);
          state_d = S_DN_LEFT;
        end else begin
          wr_en   = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DN_LEFT: begin
        cand_d = rd_data;
        cidx_d = child_w[mhtq_pkg::SLOT_W-1:0];
        if ((child_w + 1'b1) <= total_ext) begin
          rd_en   = 1'b1;
          rd_addr = slot_addr(child_w[mhtq_pkg::SLOT_W-1:0] + 1'b1);
          state_d = S_DN_RIGHT;
        end else begin
          state_d = S_DN_CMP;
        end
      end
      S_DN_RIGHT: begin
        // The right child wins only when strictly earlier.
        if (cmp_lt) begin
          cand_d = rd_data;
          cidx_d = cidx_q + 1'b1;
        end
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (cmp_lt) begin
          wr_data = cand_q;
          pos_d   = cidx_q;
          state_d = S_DN_CHK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    cidx_q  <= cidx_d;
    t_q     <= t_d;
    now_q   <= now_d;
    job_q   <= job_d;
    cand_q  <= cand_d;
    fired_q <= fired_d;
    jout_q  <= jout_d;
    drop_q  <= drop_d;
  end

  assign idle_o        = (state_q == S_IDLE);
  assign res_valid_o   = (state_q == S_DONE);
  assign res_o.fired   = fired_q;
  assign res_o.job_out = jout_q;
  assign res_o.pending = mhtq_pkg::PENDING_W'(total_q);
  assign res_o.dropped = drop_q;

endmodule

`default_nettype wire

### src/mhtq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mhtq_props (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                s_axis_tvalid,
  input wire logic                                s_axis_tready,
  input wire logic [mhtq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input wire logic [mhtq_pkg::KIND_W-1:0]         s_axis_tuser,
  input wire logic                                m_axis_tvalid,
  input wire logic                                m_axis_tready,
  input wire logic [mhtq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input wire logic [0:0]                          m_axis_tuser
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // One word at a time: after an accept the input side closes.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a word is in work");

  a_pending_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[22:16] <= mhtq_pkg::PENDING_W'(mhtq_pkg::HEAP_DEPTH)))
    else $error("pending count beyond heap depth");

  a_fire_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tdata[23]))
    else $error("fired and dropped in one word");

  a_idle_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata[15:0] == '0))
    else $error("job handle reported without a fire");

endmodule

bind min_heap_timer_queue_core mhtq_props u_mhtq_props (.*);

`default_nettype wire
